@@ rtl/ilp_pkg.sv @@
`default_nettype none

package ilp_pkg;

  localparam int DATA_W      = 8;
  localparam int POS_W       = 9;
  localparam int LIMIT_W     = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_INTERP_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ARG_LIMIT    = CFG_IDX_W'(1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

  localparam logic [DATA_W-1:0] CH_HASH  = 8'h23;
  localparam logic [DATA_W-1:0] CH_BANG  = 8'h21;
  localparam logic [DATA_W-1:0] CH_NL    = 8'h0a;
  localparam logic [DATA_W-1:0] CH_CR    = 8'h0d;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    ST_NOT_SCRIPT,
    ST_OK,
    ST_NO_INTERP,
    ST_TOO_LONG
  } status_t;

  typedef enum logic [2:0] {
    CLS_HASH,
    CLS_BANG,
    CLS_NEWLINE,
    CLS_CR,
    CLS_BLANK,
    CLS_OTHER
  } byte_cls_t;

  typedef enum logic [2:0] {
    PH_HASH,
    PH_BANG,
    PH_LEAD,
    PH_NAME,
    PH_GAP,
    PH_ARG,
    PH_DONE
  } phase_t;

  typedef struct packed {
    byte_cls_t cls;
    logic      last;
  } item_t;

  typedef struct packed {
    logic    direct;
    status_t status;
    logic    lead;
    logic    name;
    logic    arg;
  } settle_ctl_t;

endpackage

`default_nettype wire

@@ rtl/interpreter_line_parser.sv @@
`default_nettype none

// Parses a "#!interpreter [arg]" line from a byte stream, one byte per cycle
// sustained while the output keeps moving, with last marking the final byte
// of each buffer. One result comes out per buffer: a status (not a script,
// ok, no interpreter or truncated line, name too long) with the start and
// length of the interpreter name and of the optional argument. The result
// leaves through the input queue, the settle request register and the
// output register after the byte that settles it; bytes after the result up
// to last are consumed and dropped. Input throughput is set by the phase
// machine, which retires one queued byte per cycle while the output stage
// keeps moving; a stalled output backs up into a four-entry queue before
// in_ready drops. Configuration (interp_limit at index 0, arg_limit at
// index 1) is always ready and should be written only while the block is
// idle. BUF_BYTES sets the position at which a line without a newline is
// reported as truncated.
module interpreter_line_parser #(
  parameter int BUF_BYTES = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ilp_pkg::DATA_W-1:0]    data_byte,
  input  wire logic                          last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         status,
  output logic [ilp_pkg::POS_W-1:0]          interp_start,
  output logic [ilp_pkg::POS_W-1:0]          interp_length,
  output logic                               has_arg,
  output logic [ilp_pkg::POS_W-1:0]          arg_start,
  output logic [ilp_pkg::POS_W-1:0]          arg_length,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ilp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ilp_pkg::LIMIT_W-1:0]   cfg_data
);

  localparam int PW = $clog2(BUF_BYTES + 1);

  logic [ilp_pkg::LIMIT_W-1:0] interp_limit;
  logic [ilp_pkg::LIMIT_W-1:0] arg_limit;

  logic                 q_full;
  logic                 push;
  ilp_pkg::item_t       push_item;
  logic                 q_valid;
  ilp_pkg::item_t       q_item;
  logic                 pop;
  logic                 sreq_valid;
  logic                 sreq_ready;
  ilp_pkg::settle_ctl_t sreq_ctl;
  logic [PW-1:0]        sreq_tb, sreq_ts, sreq_ob, sreq_te;
  ilp_pkg::status_t     res_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_limit <= ilp_pkg::LIMIT_RESET;
      arg_limit    <= ilp_pkg::LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ilp_pkg::REG_INTERP_LIMIT: interp_limit <= cfg_data;
        ilp_pkg::REG_ARG_LIMIT:    arg_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ilp_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last      (last),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  ilp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_item)
  );

  ilp_back #(
    .BUF_BYTES (BUF_BYTES),
    .PW        (PW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .pop        (pop),
    .sreq_valid (sreq_valid),
    .sreq_ready (sreq_ready),
    .sreq_ctl   (sreq_ctl),
    .sreq_tb    (sreq_tb),
    .sreq_ts    (sreq_ts),
    .sreq_ob    (sreq_ob),
    .sreq_te    (sreq_te)
  );

  ilp_settle #(
    .PW (PW)
  ) u_settle (
    .clk               (clk),
    .rst               (rst),
    .sreq_valid        (sreq_valid),
    .sreq_ready        (sreq_ready),
    .sreq_ctl          (sreq_ctl),
    .sreq_tb           (sreq_tb),
    .sreq_ts           (sreq_ts),
    .sreq_ob           (sreq_ob),
    .sreq_te           (sreq_te),
    .interp_limit      (interp_limit),
    .arg_limit         (arg_limit),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .res_status        (res_status),
    .res_interp_start  (interp_start),
    .res_interp_length (interp_length),
    .res_has_arg       (has_arg),
    .res_arg_start     (arg_start),
    .res_arg_length    (arg_length)
  );

  assign status = res_status;

`ifndef SYNTHESIS
  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ilp_pkg::ST_OK) |->
      (interp_length == '0) && !has_arg && (arg_length == '0))
    else $error("failed parse carries nonzero fields");

  a_arg_needs_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_arg |-> (status == ilp_pkg::ST_OK))
    else $error("argument flagged without ok status");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> q_valid)
    else $error("accepted request missing from queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && !sreq_valid)
    else $error("output pending right after reset");
`endif

endmodule

`default_nettype wire

@@ rtl/ilp_front.sv @@
`default_nettype none

module ilp_front (
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [ilp_pkg::DATA_W-1:0] data_byte,
  input  wire logic                       last,
  input  wire logic                       q_full,
  output logic                            push,
  output ilp_pkg::item_t                  push_item
);

  ilp_pkg::byte_cls_t cls;

  always_comb begin
    case (data_byte)
      ilp_pkg::CH_HASH:  cls = ilp_pkg::CLS_HASH;
      ilp_pkg::CH_BANG:  cls = ilp_pkg::CLS_BANG;
      ilp_pkg::CH_NL:    cls = ilp_pkg::CLS_NEWLINE;
      ilp_pkg::CH_CR:    cls = ilp_pkg::CLS_CR;
      ilp_pkg::CH_SPACE: cls = ilp_pkg::CLS_BLANK;
      ilp_pkg::CH_TAB:   cls = ilp_pkg::CLS_BLANK;
      default:           cls = ilp_pkg::CLS_OTHER;
    endcase
  end

  assign in_ready       = !q_full;
  assign push           = in_valid && !q_full;
  assign push_item.cls  = cls;
  assign push_item.last = last;

endmodule

`default_nettype wire

@@ rtl/ilp_queue.sv @@
`default_nettype none

module ilp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ilp_pkg::item_t  push_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output ilp_pkg::item_t       head
);

  ilp_pkg::item_t               slots [ilp_pkg::QUEUE_DEPTH];
  logic [ilp_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ilp_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ilp_pkg::QPTR_W:0]     count;

  assign full  = count == (ilp_pkg::QPTR_W+1)'(ilp_pkg::QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/ilp_back.sv @@
`default_nettype none

module ilp_back #(
  parameter int BUF_BYTES = 256,
  parameter int PW        = 9
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire ilp_pkg::item_t  q_item,
  output logic                 pop,
  output logic                 sreq_valid,
  input  wire logic            sreq_ready,
  output ilp_pkg::settle_ctl_t sreq_ctl,
  output logic [PW-1:0]        sreq_tb,
  output logic [PW-1:0]        sreq_ts,
  output logic [PW-1:0]        sreq_ob,
  output logic [PW-1:0]        sreq_te
);

  localparam logic [PW-1:0] LAST_POS = PW'(BUF_BYTES - 1);

  ilp_pkg::phase_t      phase, phase_next;
  logic [PW-1:0]        pos, pos_next;
  logic [PW-1:0]        tb, tb_next;
  logic [PW-1:0]        ts, ts_next;
  logic [PW-1:0]        ob, ob_next;
  logic [PW-1:0]        te, te_next;
  logic                 emit;
  ilp_pkg::settle_ctl_t ctl;
  ilp_pkg::phase_t      flag_phase;
  logic                 step;

  assign step = q_valid && (!sreq_valid || sreq_ready);
  assign pop  = step;

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    tb_next    = tb;
    ts_next    = ts;
    ob_next    = ob;
    te_next    = te;
    emit       = 1'b0;
    ctl        = '0;
    ctl.status = ilp_pkg::ST_NOT_SCRIPT;
    case (phase)
      ilp_pkg::PH_HASH: begin
        if (q_item.cls != ilp_pkg::CLS_HASH || q_item.last) begin
          emit       = 1'b1;
          ctl.direct = 1'b1;
        end else begin
          phase_next = ilp_pkg::PH_BANG;
          pos_next   = PW'(1);
        end
      end
      ilp_pkg::PH_BANG: begin
        if (q_item.cls != ilp_pkg::CLS_BANG) begin
          emit       = 1'b1;
          ctl.direct = 1'b1;
        end else if (q_item.last) begin
          emit       = 1'b1;
          ctl.direct = 1'b1;
          ctl.status = ilp_pkg::ST_NO_INTERP;
        end else begin
          phase_next = ilp_pkg::PH_LEAD;
          pos_next   = PW'(2);
        end
      end
      ilp_pkg::PH_LEAD, ilp_pkg::PH_NAME, ilp_pkg::PH_GAP, ilp_pkg::PH_ARG: begin
        if (q_item.cls == ilp_pkg::CLS_NEWLINE) begin
          emit = 1'b1;
        end else begin
          if (q_item.cls == ilp_pkg::CLS_BLANK) begin
            if (phase == ilp_pkg::PH_NAME) begin
              ts_next    = pos;
              phase_next = ilp_pkg::PH_GAP;
            end
          end else begin
            if (phase == ilp_pkg::PH_LEAD) begin
              tb_next    = pos;
              phase_next = ilp_pkg::PH_NAME;
            end else if (phase == ilp_pkg::PH_GAP) begin
              ob_next    = pos;
              phase_next = ilp_pkg::PH_ARG;
            end
            if (q_item.cls != ilp_pkg::CLS_CR) begin
              te_next = pos + PW'(1);
            end
          end
          if (pos == LAST_POS) begin
            emit       = 1'b1;
            ctl.direct = 1'b1;
            ctl.status = ilp_pkg::ST_NO_INTERP;
          end else if (q_item.last) begin
            emit = 1'b1;
          end else begin
            pos_next = pos + PW'(1);
          end
        end
      end
      default: begin
      end
    endcase

    flag_phase = phase_next;
    ctl.lead   = flag_phase == ilp_pkg::PH_LEAD;
    ctl.name   = flag_phase == ilp_pkg::PH_NAME;
    ctl.arg    = flag_phase == ilp_pkg::PH_ARG;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= ilp_pkg::PH_HASH;
      pos        <= '0;
      tb         <= '0;
      ts         <= '0;
      ob         <= '0;
      te         <= PW'(2);
      sreq_valid <= 1'b0;
    end else begin
      if (step) begin
        if (q_item.last) begin
          phase <= ilp_pkg::PH_HASH;
          pos   <= '0;
          tb    <= '0;
          ts    <= '0;
          ob    <= '0;
          te    <= PW'(2);
        end else begin
          phase <= emit ? ilp_pkg::PH_DONE : phase_next;
          pos   <= pos_next;
          tb    <= tb_next;
          ts    <= ts_next;
          ob    <= ob_next;
          te    <= te_next;
        end
      end
      sreq_valid <= (sreq_valid && !sreq_ready) || (step && emit);
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      sreq_ctl <= ctl;
      sreq_tb  <= tb_next;
      sreq_ts  <= ts_next;
      sreq_ob  <= ob_next;
      sreq_te  <= te_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ilp_settle.sv @@
`default_nettype none

module ilp_settle #(
  parameter int PW = 9
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        sreq_valid,
  output logic                             sreq_ready,
  input  wire ilp_pkg::settle_ctl_t        sreq_ctl,
  input  wire logic [PW-1:0]               sreq_tb,
  input  wire logic [PW-1:0]               sreq_ts,
  input  wire logic [PW-1:0]               sreq_ob,
  input  wire logic [PW-1:0]               sreq_te,
  input  wire logic [ilp_pkg::LIMIT_W-1:0] interp_limit,
  input  wire logic [ilp_pkg::LIMIT_W-1:0] arg_limit,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ilp_pkg::status_t                 res_status,
  output logic [ilp_pkg::POS_W-1:0]        res_interp_start,
  output logic [ilp_pkg::POS_W-1:0]        res_interp_length,
  output logic                             res_has_arg,
  output logic [ilp_pkg::POS_W-1:0]        res_arg_start,
  output logic [ilp_pkg::POS_W-1:0]        res_arg_length
);

  localparam int LW = ilp_pkg::LIMIT_W;
  localparam int OW = ilp_pkg::POS_W;

  logic [LW-1:0]    tb, ts, ob, te, stop, ilen, alen, alen_clip;
  ilp_pkg::status_t st;
  logic [OW-1:0]    is_v, il_v, as_v, al_v;
  logic             ha_v;
  logic             take;

  assign sreq_ready = !out_valid || out_ready;
  assign take       = sreq_valid && sreq_ready;

  assign tb   = LW'(sreq_tb);
  assign ts   = LW'(sreq_ts);
  assign ob   = LW'(sreq_ob);
  assign te   = LW'(sreq_te);
  assign stop = (sreq_ctl.name || ts > te) ? te : ts;
  assign ilen = stop - tb;
  assign alen = te - ob;

  always_comb begin
    alen_clip = alen;
    if (alen >= arg_limit) begin
      alen_clip = (arg_limit == '0) ? '0 : arg_limit - LW'(1);
    end
  end

  always_comb begin
    st   = ilp_pkg::ST_OK;
    is_v = '0;
    il_v = '0;
    ha_v = 1'b0;
    as_v = '0;
    al_v = '0;
    if (sreq_ctl.direct) begin
      st = sreq_ctl.status;
    end else if (sreq_ctl.lead || tb >= te) begin
      st = ilp_pkg::ST_NO_INTERP;
    end else if (ilen >= interp_limit) begin
      st = ilp_pkg::ST_TOO_LONG;
    end else begin
      is_v = tb[OW-1:0];
      il_v = ilen[OW-1:0];
      if (sreq_ctl.arg && ob < te) begin
        ha_v = 1'b1;
        as_v = ob[OW-1:0];
        al_v = alen_clip[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sreq_ready) begin
      out_valid <= sreq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_status        <= st;
      res_interp_start  <= is_v;
      res_interp_length <= il_v;
      res_has_arg       <= ha_v;
      res_arg_start     <= as_v;
      res_arg_length    <= al_v;
    end
  end

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int BUF_BYTES      = 256;
  localparam int HOLD_CYCLES    = 150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam int DW = ilp_pkg::DATA_W;
  localparam int PW = ilp_pkg::POS_W;
  localparam int LW = ilp_pkg::LIMIT_W;
  localparam int IW = ilp_pkg::CFG_IDX_W;

  localparam logic [IW-1:0] REG_UNUSED_2 = IW'(2);
  localparam logic [IW-1:0] REG_UNUSED_3 = IW'(3);

  typedef struct packed {
    ilp_pkg::status_t status;
    logic [PW-1:0]    interp_start;
    logic [PW-1:0]    interp_length;
    logic             has_arg;
    logic [PW-1:0]    arg_start;
    logic [PW-1:0]    arg_length;
  } line_result_t;

  typedef enum logic [1:0] {
    LK_SCRIPT,
    LK_BROKEN,
    LK_NOISE
  } line_kind_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] data_byte = '0;
  logic          last = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [1:0]    status;
  logic [PW-1:0] interp_start;
  logic [PW-1:0] interp_length;
  logic          has_arg;
  logic [PW-1:0] arg_start;
  logic [PW-1:0] arg_length;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [IW-1:0] cfg_index = '0;
  logic [LW-1:0] cfg_data = '0;

  // shadow of the parser state and limit registers
  ilp_pkg::phase_t phase;
  int unsigned     pos_q;
  int unsigned     tok_begin;
  int unsigned     tok_stop;
  int unsigned     opt_begin;
  int unsigned     trim_end;
  logic [LW-1:0]   lim_interp;
  logic [LW-1:0]   lim_arg;

  line_result_t  pending_results[$];
  logic [DW-1:0] line_q[$];
  int            mismatches = 0;
  int            bytes_sent = 0;
  int            quiet_cycles = 0;
  bit            in_idle = 1'b1;
  bit            out_idle = 1'b1;
  bit            hold_req = 1'b0;

  interpreter_line_parser #(.BUF_BYTES(BUF_BYTES)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last(last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .interp_start(interp_start),
    .interp_length(interp_length),
    .has_arg(has_arg),
    .arg_start(arg_start),
    .arg_length(arg_length),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void clear_line();
    phase = ilp_pkg::PH_HASH;
    pos_q = 0;
    tok_begin = 0;
    tok_stop = 0;
    opt_begin = 0;
    trim_end = 2;
  endfunction

  function automatic line_result_t settle_line(input bit truncated);
    line_result_t r;
    int unsigned  stop;
    int unsigned  ilen;
    int unsigned  alen;
    r = '0;
    if (truncated || phase == ilp_pkg::PH_LEAD || tok_begin >= trim_end) begin
      r.status = ilp_pkg::ST_NO_INTERP;
      return r;
    end
    stop = (phase == ilp_pkg::PH_NAME || tok_stop > trim_end) ? trim_end : tok_stop;
    ilen = stop - tok_begin;
    if (ilen >= lim_interp) begin
      r.status = ilp_pkg::ST_TOO_LONG;
      return r;
    end
    r.status = ilp_pkg::ST_OK;
    r.interp_start = PW'(tok_begin);
    r.interp_length = PW'(ilen);
    if (phase == ilp_pkg::PH_ARG && opt_begin < trim_end) begin
      alen = trim_end - opt_begin;
      if (alen >= lim_arg)
        alen = (lim_arg > 0) ? lim_arg - 1 : 0;
      r.has_arg = 1'b1;
      r.arg_start = PW'(opt_begin);
      r.arg_length = PW'(alen);
    end
    return r;
  endfunction

  function automatic bit parse_byte(input logic [DW-1:0] b, input logic l,
                                    output line_result_t r);
    bit          done;
    int unsigned p;
    done = 1'b0;
    p = pos_q;
    r = '0;
    case (phase)
      ilp_pkg::PH_HASH: begin
        if (b != ilp_pkg::CH_HASH || l) begin
          r.status = ilp_pkg::ST_NOT_SCRIPT;
          done = 1'b1;
        end else begin
          phase = ilp_pkg::PH_BANG;
          pos_q = 1;
        end
      end
      ilp_pkg::PH_BANG: begin
        if (b != ilp_pkg::CH_BANG) begin
          r.status = ilp_pkg::ST_NOT_SCRIPT;
          done = 1'b1;
        end else if (l) begin
          r.status = ilp_pkg::ST_NO_INTERP;
          done = 1'b1;
        end else begin
          phase = ilp_pkg::PH_LEAD;
          pos_q = 2;
        end
      end
      ilp_pkg::PH_LEAD, ilp_pkg::PH_NAME, ilp_pkg::PH_GAP, ilp_pkg::PH_ARG: begin
        if (b == ilp_pkg::CH_NL) begin
          r = settle_line(1'b0);
          done = 1'b1;
        end else begin
          if (b == ilp_pkg::CH_SPACE || b == ilp_pkg::CH_TAB) begin
            if (phase == ilp_pkg::PH_NAME) begin
              tok_stop = p;
              phase = ilp_pkg::PH_GAP;
            end
          end else begin
            if (phase == ilp_pkg::PH_LEAD) begin
              tok_begin = p;
              phase = ilp_pkg::PH_NAME;
            end else if (phase == ilp_pkg::PH_GAP) begin
              opt_begin = p;
              phase = ilp_pkg::PH_ARG;
            end
            if (b != ilp_pkg::CH_CR)
              trim_end = p + 1;
          end
          if (p + 1 >= BUF_BYTES) begin
            r = settle_line(1'b1);
            done = 1'b1;
          end else if (l) begin
            r = settle_line(1'b0);
            done = 1'b1;
          end else begin
            pos_q = p + 1;
          end
        end
      end
      default: ;
    endcase
    if (l)
      clear_line();
    else if (done)
      phase = ilp_pkg::PH_DONE;
    return done;
  endfunction

  function automatic void log_failure(input string what, input line_result_t got,
                                      input line_result_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s at %0t: got st=%0d is=%0d il=%0d ha=%0b as=%0d al=%0d", what, $time,
               got.status, got.interp_start, got.interp_length, got.has_arg,
               got.arg_start, got.arg_length);
      $display("  exp st=%0d is=%0d il=%0d ha=%0b as=%0d al=%0d", want.status,
               want.interp_start, want.interp_length, want.has_arg, want.arg_start,
               want.arg_length);
    end
  endfunction

  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    if (!rst && out_valid && out_ready) begin
      got.status = ilp_pkg::status_t'(status);
      got.interp_start = interp_start;
      got.interp_length = interp_length;
      got.has_arg = has_arg;
      got.arg_start = arg_start;
      got.arg_length = arg_length;
      if (pending_results.size() == 0) begin
        log_failure("unexpected result", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          log_failure("mismatch", got, want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side: per-request stall, or a long hold when asked
  initial begin : receiver
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, 10) : 0;
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_byte(input logic [DW-1:0] b, input logic l);
    int           gap;
    line_result_t r;
    gap = in_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    last <= l;
    do @(posedge clk); while (!in_ready);
    if (parse_byte(b, l, r))
      pending_results.push_back(r);
    bytes_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++)
      send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [LW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ilp_pkg::REG_INTERP_LIMIT: lim_interp = val;
      ilp_pkg::REG_ARG_LIMIT:    lim_arg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [LW-1:0] il, input logic [LW-1:0] al);
    wait_idle();
    write_reg(ilp_pkg::REG_INTERP_LIMIT, il);
    write_reg(ilp_pkg::REG_ARG_LIMIT, al);
  endtask

  function automatic logic [DW-1:0] rand_token_byte();
    logic [DW-1:0] b;
    if ($urandom_range(0, 15) == 0)
      return ilp_pkg::CH_CR;
    do b = DW'($urandom_range(0, 255));
    while (b == ilp_pkg::CH_SPACE || b == ilp_pkg::CH_TAB || b == ilp_pkg::CH_NL);
    return b;
  endfunction

  function automatic logic [DW-1:0] rand_blank();
    return $urandom_range(0, 1) ? ilp_pkg::CH_SPACE : ilp_pkg::CH_TAB;
  endfunction

  function automatic logic [DW-1:0] rand_trail();
    case ($urandom_range(0, 2))
      0: return ilp_pkg::CH_SPACE;
      1: return ilp_pkg::CH_TAB;
      default: return ilp_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [LW-1:0] pick_limit();
    if ($urandom_range(0, 9) == 0)
      return LW'($urandom_range(0, 8191));
    return LW'($urandom_range(0, 14));
  endfunction

  // "#!" [blanks] name [blanks arg] [trailing blanks/cr] [newline junk]
  task automatic gen_script(input int name_max, input int arg_max);
    line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG};
    repeat ($urandom_range(0, 3)) line_q.push_back(rand_blank());
    repeat ($urandom_range(1, name_max)) line_q.push_back(rand_token_byte());
    if ($urandom_range(0, 2) != 0) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(rand_blank());
      repeat ($urandom_range(1, arg_max))
        line_q.push_back(($urandom_range(0, 5) == 0) ? rand_blank() : rand_token_byte());
    end
    repeat ($urandom_range(0, 3)) line_q.push_back(rand_trail());
    if ($urandom_range(0, 3) != 0) begin
      line_q.push_back(ilp_pkg::CH_NL);
      repeat ($urandom_range(0, 3)) line_q.push_back(DW'($urandom_range(0, 255)));
    end
  endtask

  task automatic gen_broken();
    case ($urandom_range(0, 3))
      0: line_q = '{ilp_pkg::CH_HASH, DW'($urandom_range(0, 255))};
      1: begin
        line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG};
        repeat ($urandom_range(0, 4)) line_q.push_back(rand_trail());
        if ($urandom_range(0, 1))
          line_q.push_back(ilp_pkg::CH_NL);
      end
      2: line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG};
      default: begin
        line_q = '{rand_token_byte(), ilp_pkg::CH_HASH, ilp_pkg::CH_BANG};
        repeat ($urandom_range(0, 4)) line_q.push_back(rand_token_byte());
      end
    endcase
  endtask

  task automatic gen_line(input line_kind_t kind);
    case (kind)
      LK_SCRIPT: gen_script(12, 12);
      LK_BROKEN: gen_broken();
      default: begin
        line_q = {};
        repeat ($urandom_range(1, 8)) line_q.push_back(DW'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic test_directed();
    line_q = '{8'hFF};
    send_line();
    line_q = '{ilp_pkg::CH_HASH};
    send_line();
    // settled on the first byte, the rest is dropped
    line_q = '{8'hFF, ilp_pkg::CH_HASH};
    send_line();
    line_q = '{ilp_pkg::CH_HASH, 8'h3F};
    send_line();
    line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG};
    send_line();
    line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG, ilp_pkg::CH_NL};
    send_line();
    // cr inside the name, trailing cr trimmed
    line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG, ilp_pkg::CH_TAB, 8'h61, ilp_pkg::CH_CR,
               8'h62, ilp_pkg::CH_SPACE, 8'h63, ilp_pkg::CH_CR};
    send_line();
    line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG, 8'h73, ilp_pkg::CH_TAB, 8'h78,
               ilp_pkg::CH_SPACE, 8'h79, ilp_pkg::CH_SPACE, ilp_pkg::CH_NL, 8'h00};
    send_line();
  endtask

  task automatic test_reg_extremes();
    logic [LW-1:0] il[6] = '{13'd0, 13'd1, 13'h1FFF, 13'd4, 13'd4096, ilp_pkg::LIMIT_RESET};
    logic [LW-1:0] al[6] = '{13'd0, 13'd1, 13'd0, 13'd1, 13'd3, ilp_pkg::LIMIT_RESET};
    for (int s = 0; s < 6; s++) begin
      set_limits(il[s], al[s]);
      if (s == 5) begin
        write_reg(REG_UNUSED_2, 13'h1FFF);
        write_reg(REG_UNUSED_3, LW'($urandom_range(0, 8191)));
      end
      gen_script(6, 6);
      send_line();
    end
  endtask

  task automatic test_full_buffer();
    set_limits(13'h1FFF, 13'd100);
    // no newline before the end of the buffer, tail ignored
    line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG, ilp_pkg::CH_SPACE};
    while (line_q.size() < BUF_BYTES) line_q.push_back(rand_token_byte());
    repeat ($urandom_range(0, 3)) line_q.push_back(DW'($urandom_range(0, 255)));
    send_line();
    // newline in the final slot, long argument clipped
    line_q = '{ilp_pkg::CH_HASH, ilp_pkg::CH_BANG, 8'h61, ilp_pkg::CH_SPACE};
    while (line_q.size() < BUF_BYTES - 1) line_q.push_back(rand_token_byte());
    line_q.push_back(ilp_pkg::CH_NL);
    send_line();
  endtask

  task automatic test_backpressure();
    set_limits(ilp_pkg::LIMIT_RESET, ilp_pkg::LIMIT_RESET);
    in_idle = 1'b0;
    hold_req = 1'b1;
    repeat (6) begin
      gen_script(4, 4);
      send_line();
    end
    wait_idle();
    in_idle = 1'b1;
  endtask

  task automatic test_random_lines();
    int         stop_at;
    int         k;
    line_kind_t kind;
    for (int ph = 0; ph < 6; ph++) begin
      set_limits(pick_limit(), pick_limit());
      in_idle = (ph != 2 && ph != 5);
      out_idle = (ph != 1 && ph != 5);
      stop_at = bytes_sent + 12;
      while (bytes_sent < stop_at) begin
        k = $urandom_range(0, 9);
        kind = (k < 7) ? LK_SCRIPT : (k < 9) ? LK_BROKEN : LK_NOISE;
        gen_line(kind);
        send_line();
      end
    end
    in_idle = 1'b1;
    out_idle = 1'b1;
  endtask

  initial begin
    clear_line();
    lim_interp = ilp_pkg::LIMIT_RESET;
    lim_arg = ilp_pkg::LIMIT_RESET;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_reg_extremes();
    test_full_buffer();
    test_backpressure();
    test_random_lines();
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
